### hdl/bpa_pkg.sv
// bpa_pkg: shared types and constants of the bitmap page allocator
`default_nettype none
package bpa_pkg;

   localparam int unsigned NUM_PAGES_DEFAULT = 1024;

   // field widths
   localparam int unsigned ADDR_BITS   = 32;
   localparam int unsigned CNT_BITS    = 11;
   localparam int unsigned SHIFT_BITS  = 5;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned CSR_IDX_BITS = 2;

   // bitmap word geometry
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned WORD_LSB   = 5;
   localparam int unsigned WIDX_BITS  = CNT_BITS - WORD_LSB;
   localparam int unsigned RUN_BITS   = CNT_BITS + 1;
   localparam int unsigned LP_BITS    = WORD_LSB + 1;
   localparam int unsigned CNT_MAX    = (1 << CNT_BITS) - 1;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_RUN = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAGE_SHIFT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAGES_IN_USE = 2'd2;

   // register reset values
   localparam logic [ADDR_BITS-1:0]  BASE_ADDRESS_RESET = 32'h0010_0000;
   localparam logic [SHIFT_BITS-1:0] PAGE_SHIFT_RESET   = 5'd12;
   localparam logic [CNT_BITS-1:0]   PAGES_IN_USE_RESET = 11'd1024;

   typedef struct packed {
      logic                  op;
      logic [CNT_BITS-1:0]   run_pages;
      logic [ADDR_BITS-1:0]  address;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   result_address;
      logic [STATUS_BITS-1:0] status;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ACHK,
      S_SCAN,
      S_AFIRST,
      S_FCHK,
      S_FRANGE,
      S_APPLY_RD,
      S_APPLY,
      S_DONE
   } bpa_state_type;

endpackage
`default_nettype wire

### hdl/bitmap_page_allocator.sv
// bitmap_page_allocator: first-fit contiguous page allocator over a bitmap memory
`default_nettype none
// steps: alloc checks the count, scans bitmap words from word 0 (at most ceil(live pages / 32)),
//   then fixes the run start, reads the first word and marks one word per step; a zero or oversized
//   count or a scan with no run goes to done; free checks the range, then clears words the same way
// throughput: one word at a time, busy drops with the strobe so the next word can be
//   accepted at the edge that ends the strobe cycle; results are a one-cycle strobe
// reset: synchronous, then a clearing pass zeroes one memory word per cycle, busy until the last word
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int unsigned NUM_PAGES = NUM_PAGES_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   // request side
   input  wire                       start,
   output logic                      busy,
   input  wire req_word_type         req_word,
   // result side
   output logic                      rsp_valid,
   output rsp_word_type              rsp_word,
   // register port
   input  wire                       csr_we,
   input  wire [CSR_IDX_BITS-1:0]    csr_index,
   input  wire [ADDR_BITS-1:0]       csr_wdata
);

   // memory geometry follows the page count
   localparam int unsigned WORDS   = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned MADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   // reachable pages: the page count field caps what a request can touch
   localparam int unsigned CAP_INT = (NUM_PAGES > CNT_MAX) ? CNT_MAX : NUM_PAGES;
   localparam logic [CNT_BITS-1:0]  LIVE_CAP  = CNT_BITS'(CAP_INT);
   localparam logic [MADDR_W-1:0]   LAST_WORD = MADDR_W'(WORDS - 1);
   localparam logic [WORD_LSB-1:0]  TOP_BIT   = WORD_LSB'(WORD_BITS - 1);

   // configuration registers
   logic [ADDR_BITS-1:0]  base_ff;
   logic [SHIFT_BITS-1:0] shift_ff;
   logic [CNT_BITS-1:0]   piu_ff;

   // control
   bpa_state_type         state_ff, state_in;
   logic [MADDR_W-1:0]    clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic                  op_ff, op_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [ADDR_BITS-1:0]  off_ff, off_in;
   logic                  below_ff, below_in;
   logic [WIDX_BITS-1:0]  scan_w_ff, scan_w_in;
   logic [CNT_BITS-1:0]   run_ff, run_in;
   logic [CNT_BITS-1:0]   ap_s_ff, ap_s_in;
   logic [CNT_BITS-1:0]   ap_e_ff, ap_e_in;
   logic [WIDX_BITS-1:0]  ap_w_ff, ap_w_in;
   logic [STATUS_BITS-1:0] st_ff, st_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   // bitmap memory
   logic [WORD_BITS-1:0]  mem [0:WORDS-1];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [MADDR_W-1:0]    mem_ra;
   logic [MADDR_W-1:0]    mem_wa;
   logic [WORD_BITS-1:0]  mem_wd;
   logic                  mem_we;

   // decisions
   logic                  accept;
   logic [CNT_BITS-1:0]   limit;
   logic [CNT_BITS-1:0]   lim_m1;
   logic [WIDX_BITS-1:0]  last_w;
   logic                  achk_fail;
   logic                  free_bad;

   // scan datapath
   logic [WORD_BITS-1:0]  valid_mask;
   logic [WORD_BITS-1:0]  used_w;
   logic [LP_BITS-1:0]    lp [0:WORD_LSB][0:WORD_BITS-1];
   logic [RUN_BITS-1:0]   run_j [0:WORD_BITS-1];
   logic [WORD_BITS-1:0]  hit_v;
   logic [WORD_BITS-1:0]  hit_low;
   logic [WORD_LSB-1:0]   hit_idx;
   logic                  scan_hit;

   // apply datapath
   logic [WORD_LSB-1:0]   ap_lo;
   logic [WORD_LSB-1:0]   ap_hi;
   logic [WORD_BITS-1:0]  ap_mask;
   logic                  ap_last;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // pages beyond the hardware act as absent
   assign limit     = (piu_ff > LIVE_CAP) ? LIVE_CAP : piu_ff;
   assign lim_m1    = limit - 1'b1;
   assign last_w    = lim_m1[CNT_BITS-1:WORD_LSB];
   assign achk_fail = (cnt_ff == '0) || (cnt_ff > limit);
   assign free_bad  = below_ff ||
                      ((33'(off_ff) + 33'(cnt_ff)) > 33'(limit));

   // ---------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_ADDRESS_RESET;
         shift_ff <= PAGE_SHIFT_RESET;
         piu_ff   <= PAGES_IN_USE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_ADDRESS: base_ff  <= csr_wdata;
            CSR_PAGE_SHIFT:   shift_ff <= csr_wdata[SHIFT_BITS-1:0];
            CSR_PAGES_IN_USE: piu_ff   <= csr_wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // bitmap memory, one read and one write port, registered read
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   // read address: the word the next cycle will look at
   always_comb begin
      case (state_ff)
         S_SCAN:     mem_ra = MADDR_W'(scan_w_ff + 1'b1);
         S_APPLY_RD: mem_ra = MADDR_W'(ap_s_ff[CNT_BITS-1:WORD_LSB]);
         S_APPLY:    mem_ra = MADDR_W'(ap_w_ff + 1'b1);
         default:    mem_ra = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // scan of one bitmap word against the run carried in from below
   // ---------------------------------------------------------------
   // pages past the live limit count as used so no run crosses it
   assign valid_mask = (scan_w_ff == last_w) ?
                       ({WORD_BITS{1'b1}} >> (TOP_BIT - lim_m1[WORD_LSB-1:0])) :
                       {WORD_BITS{1'b1}};
   assign used_w     = rd_data_ff | ~valid_mask;

   always_comb begin
      // lp holds one plus the position of the highest used bit at or below j
      for (int j = 0; j < WORD_BITS; j++) begin
         lp[0][j] = used_w[j] ? LP_BITS'(j + 1) : '0;
      end
      // prefix max in log steps
      for (int s = 0; s < WORD_LSB; s++) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            lp[s+1][j] = lp[s][j];
            if (j >= (1 << s)) begin
               if (lp[s][j - (1 << s)] > lp[s][j]) begin
                  lp[s+1][j] = lp[s][j - (1 << s)];
               end
            end
         end
      end
      // free run ending at each bit
      for (int j = 0; j < WORD_BITS; j++) begin
         if (lp[WORD_LSB][j] == '0) begin
            run_j[j] = RUN_BITS'(run_ff) + RUN_BITS'(j + 1);
         end else begin
            run_j[j] = RUN_BITS'(j + 1) - RUN_BITS'(lp[WORD_LSB][j]);
         end
         hit_v[j] = (run_j[j] >= RUN_BITS'(cnt_ff));
      end
   end

   assign hit_low  = hit_v & (~hit_v + 1'b1);
   assign scan_hit = (hit_v != '0);

   always_comb begin
      hit_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (hit_low[j]) begin
            hit_idx = hit_idx | WORD_LSB'(j);
         end
      end
   end

   // ---------------------------------------------------------------
   // set or clear a page range, one word per cycle
   // ---------------------------------------------------------------
   assign ap_lo   = (ap_w_ff == ap_s_ff[CNT_BITS-1:WORD_LSB]) ?
                    ap_s_ff[WORD_LSB-1:0] : '0;
   assign ap_hi   = (ap_w_ff == ap_e_ff[CNT_BITS-1:WORD_LSB]) ?
                    ap_e_ff[WORD_LSB-1:0] : TOP_BIT;
   assign ap_mask = ({WORD_BITS{1'b1}} << ap_lo) &
                    ({WORD_BITS{1'b1}} >> (TOP_BIT - ap_hi));
   assign ap_last = (ap_w_ff == ap_e_ff[CNT_BITS-1:WORD_LSB]);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = MADDR_W'(ap_w_ff);
      mem_wd = (op_ff == OP_ALLOC) ? (rd_data_ff | ap_mask) : (rd_data_ff & ~ap_mask);
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
         end
         S_APPLY: begin
            mem_we = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_WORD) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               state_in = (req_word.op == OP_ALLOC) ? S_ACHK : S_FCHK;
            end
         end
         S_ACHK: begin
            state_in = achk_fail ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            if (scan_hit)                  state_in = S_AFIRST;
            else if (scan_w_ff == last_w)  state_in = S_DONE;
         end
         S_AFIRST:   state_in = S_APPLY_RD;
         S_FCHK:     state_in = S_FRANGE;
         S_FRANGE: begin
            if (free_bad || cnt_ff == '0) state_in = S_DONE;
            else                          state_in = S_APPLY_RD;
         end
         S_APPLY_RD: state_in = S_APPLY;
         S_APPLY: begin
            if (ap_last) state_in = S_DONE;
         end
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer: datapath updates
   // ---------------------------------------------------------------
   always_comb begin
      clr_in       = clr_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      off_in       = off_ff;
      below_in     = below_ff;
      scan_w_in    = scan_w_ff;
      run_in       = run_ff;
      ap_s_in      = ap_s_ff;
      ap_e_in      = ap_e_ff;
      ap_w_in      = ap_w_ff;
      st_in        = st_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               op_in   = req_word.op;
               cnt_in  = req_word.run_pages;
               addr_in = req_word.address;
               st_in   = STATUS_OK;
            end
         end
         S_ACHK: begin
            // word 0 is being read this cycle
            scan_w_in = '0;
            run_in    = '0;
            if (achk_fail) st_in = STATUS_NO_RUN;
         end
         S_SCAN: begin
            if (scan_hit) begin
               ap_e_in = {scan_w_ff, hit_idx};
            end else begin
               scan_w_in = scan_w_ff + 1'b1;
               run_in    = run_j[WORD_BITS-1][CNT_BITS-1:0];
               if (scan_w_ff == last_w) st_in = STATUS_NO_RUN;
            end
         end
         S_AFIRST: begin
            ap_s_in = ap_e_ff + 1'b1 - cnt_ff;
         end
         S_FCHK: begin
            below_in = (addr_ff < base_ff);
            off_in   = (addr_ff - base_ff) >> shift_ff;
         end
         S_FRANGE: begin
            // in range means off + count <= limit, so both ends fit the index width
            ap_s_in = off_ff[CNT_BITS-1:0];
            ap_e_in = off_ff[CNT_BITS-1:0] + cnt_ff - 1'b1;
            st_in   = free_bad ? STATUS_RANGE : STATUS_OK;
         end
         S_APPLY_RD: begin
            ap_w_in = ap_s_ff[CNT_BITS-1:WORD_LSB];
         end
         S_APPLY: begin
            ap_w_in = ap_w_ff + 1'b1;
         end
         S_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_word_in.status  = st_ff;
            if (op_ff == OP_ALLOC && st_ff == STATUS_OK) begin
               rsp_word_in.result_address = base_ff + (ADDR_BITS'(ap_s_ff) << shift_ff);
            end else begin
               rsp_word_in.result_address = '0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      off_ff      <= off_in;
      below_ff    <= below_in;
      scan_w_ff   <= scan_w_in;
      run_ff      <= run_in;
      ap_s_ff     <= ap_s_in;
      ap_e_ff     <= ap_e_in;
      ap_w_ff     <= ap_w_in;
      st_ff       <= st_in;
      rsp_word_ff <= rsp_word_in;
   end

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // a result strobe only follows the finishing step
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE))
      else $error("result strobe without a finished item");

   // the range walk never passes its last word
   a_apply_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (ap_w_ff <= ap_e_ff[CNT_BITS-1:WORD_LSB]))
      else $error("range walk ran past its end word");

   // a granted run ends inside the live pages
   a_grant_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && op_ff == OP_ALLOC && st_ff == STATUS_OK)
         |-> (ap_e_ff < limit && ap_s_ff <= ap_e_ff))
      else $error("granted run leaves the live pages");

   // the scan only reads, the clearing pass always writes, and the block is busy in both
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_CLEAR) |-> (mem_we == (state_ff == S_CLEAR)) && busy)
      else $error("bitmap written during scan or block idle during clear");

endmodule
`default_nettype wire

### tb/tb_bitmap_page_allocator.sv
// tb_bitmap_page_allocator: self-checking testbench of the first-fit bitmap page allocator
`timescale 1ns / 100ps
module tb_bitmap_page_allocator;
   import bpa_pkg::*;

   localparam int NUM_PAGES   = NUM_PAGES_DEFAULT;
   // watchdog limit covers the slowest word plus the largest gap for ~800 words
   localparam int CYCLE_LIMIT = 800000;
   localparam int TAIL_CYCLES = 80;

   // directed rows are either a request word or a register write
   typedef enum logic {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic                      op;
      logic [CNT_BITS-1:0]       count;
      logic [CSR_IDX_BITS-1:0]   csr_idx;
      logic [ADDR_BITS-1:0]      data;       // free address, or register value
      logic                      known;      // expected word typed in below
      logic [ADDR_BITS-1:0]      exp_address;
      logic [STATUS_BITS-1:0]    exp_status;
   } stim_row_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  base;
      logic [SHIFT_BITS-1:0] shift;
      logic [CNT_BITS-1:0]   pages;
      logic [9:0]            items;
      logic                  mixed;          // draw base and shift at random
   } phase_type;

   typedef struct {
      int first;
      int len;
   } page_run_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [ADDR_BITS-1:0]    csr_wdata;

   // typed-in expectation that travels with the request word
   logic         golden_known;
   rsp_word_type golden_rsp;

   // allocator model state
   logic                  page_map [NUM_PAGES];
   logic [ADDR_BITS-1:0]  model_base;
   logic [SHIFT_BITS-1:0] model_shift;
   logic [CNT_BITS-1:0]   model_pages;

   rsp_word_type expected_rsp_q [$];
   page_run_type live_runs [$];          // runs handed out, candidates for a clean free
   int mismatch_count = 0;
   int cycle_count = 0;

   // directed part, reset settings first: extremes, refusals, then wrap and shrink
   stim_row_type dir_rows [29] = '{
      // zero, max field and oversized counts never fit; a single page takes page 0
      '{ROW_ITEM, OP_ALLOC, 11'd0,    CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0, STATUS_NO_RUN},
      '{ROW_ITEM, OP_ALLOC, 11'd1,    CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0010_0000, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd2047, CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0, STATUS_NO_RUN},
      '{ROW_ITEM, OP_ALLOC, 11'd1025, CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0, STATUS_NO_RUN},
      // fill the rest of the map, then nothing is left
      '{ROW_ITEM, OP_ALLOC, 11'd1023, CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0010_1000, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd1,    CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0, STATUS_NO_RUN},
      // below base, too long, running past the last page; then the last page and a zero count
      '{ROW_ITEM, OP_FREE,  11'd1,    CSR_BASE_ADDRESS, 32'h000F_FFFF, 1'b1, 32'h0, STATUS_RANGE},
      '{ROW_ITEM, OP_FREE,  11'd1025, CSR_BASE_ADDRESS, 32'h0010_0000, 1'b1, 32'h0, STATUS_RANGE},
      '{ROW_ITEM, OP_FREE,  11'd2,    CSR_BASE_ADDRESS, 32'h004F_F000, 1'b1, 32'h0, STATUS_RANGE},
      '{ROW_ITEM, OP_FREE,  11'd1,    CSR_BASE_ADDRESS, 32'h004F_F000, 1'b1, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_FREE,  11'd0,    CSR_BASE_ADDRESS, 32'h0010_0000, 1'b1, 32'h0, STATUS_OK},
      // misaligned free drops the offset, then free an already free page, two allocs and a wild free
      '{ROW_ITEM, OP_FREE,  11'd1,    CSR_BASE_ADDRESS, 32'h0010_0FFF, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_FREE,  11'd1,    CSR_BASE_ADDRESS, 32'h0010_0000, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd2,    CSR_BASE_ADDRESS, 32'h0, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd1,    CSR_BASE_ADDRESS, 32'h0, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_FREE,  11'd2047, CSR_BASE_ADDRESS, 32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_RANGE},
      // whole map back and forth
      '{ROW_ITEM, OP_FREE,  11'd1024, CSR_BASE_ADDRESS, 32'h0010_0000, 1'b1, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd1024, CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0010_0000, STATUS_OK},
      '{ROW_ITEM, OP_FREE,  11'd1024, CSR_BASE_ADDRESS, 32'h0010_0000, 1'b1, 32'h0, STATUS_OK},
      // high base and big pages: the answered address wraps
      '{ROW_CSR,  OP_ALLOC, 11'd0,    CSR_BASE_ADDRESS, 32'hFFFF_F000, 1'b0, 32'h0, STATUS_OK},
      '{ROW_CSR,  OP_ALLOC, 11'd0,    CSR_PAGE_SHIFT,   32'd20, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd3,    CSR_BASE_ADDRESS, 32'h0, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd1,    CSR_BASE_ADDRESS, 32'h0, 1'b0, 32'h0, STATUS_OK},
      // no pages at all, then a shrunk map with used pages above the limit
      '{ROW_CSR,  OP_ALLOC, 11'd0,    CSR_PAGES_IN_USE, 32'd0, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd1,    CSR_BASE_ADDRESS, 32'h0, 1'b1, 32'h0, STATUS_NO_RUN},
      '{ROW_ITEM, OP_FREE,  11'd0,    CSR_BASE_ADDRESS, 32'hFFFF_F000, 1'b0, 32'h0, STATUS_OK},
      '{ROW_CSR,  OP_ALLOC, 11'd0,    CSR_PAGES_IN_USE, 32'd2, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_ALLOC, 11'd2,    CSR_BASE_ADDRESS, 32'h0, 1'b0, 32'h0, STATUS_OK},
      '{ROW_ITEM, OP_FREE,  11'd3,    CSR_BASE_ADDRESS, 32'hFFFF_F000, 1'b0, 32'h0, STATUS_OK}
   };

   // random phases: register settings, extremes among them
   phase_type phases [8] = '{
      '{32'h0010_0000, 5'd12, 11'd1024, 10'd130, 1'b0},
      '{32'h0000_0000, 5'd0,  11'd8,    10'd100, 1'b0},
      '{32'hFFFF_FFFF, 5'd20, 11'd2047, 10'd110, 1'b0},
      '{32'h0,         5'd0,  11'd33,   10'd100, 1'b1},
      '{32'h0,         5'd0,  11'd1,    10'd60,  1'b1},
      '{32'h8000_0000, 5'd5,  11'd0,    10'd30,  1'b0},
      '{32'h0,         5'd0,  11'd700,  10'd110, 1'b1},
      '{32'h0010_0000, 5'd12, 11'd1024, 10'd110, 1'b0}
   };

   bitmap_page_allocator #(
      .NUM_PAGES(NUM_PAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[bitmap_page_allocator] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // first-fit allocate / range-checked free over the model bitmap
   task automatic allocator_model(input req_word_type w, output rsp_word_type r,
                                  output int first_page);
      int              lim;
      int              run;
      longint unsigned idx;
      logic [63:0]     sum;
      lim = (model_pages > NUM_PAGES) ? NUM_PAGES : int'(model_pages);
      run = 0;
      first_page = -1;
      r.result_address = '0;
      r.status = STATUS_NO_RUN;
      if (w.op == OP_ALLOC) begin
         if (w.run_pages != 0 && w.run_pages <= lim) begin
            for (int i = 0; i < lim; i++) begin
               if (page_map[i]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == w.run_pages) begin
                     first_page = i + 1 - run;
                     for (int k = first_page; k <= i; k++) page_map[k] = 1'b1;
                     // address wraps modulo 2^32
                     sum = 64'(model_base) + (64'(first_page) << model_shift);
                     r.result_address = sum[31:0];
                     r.status = STATUS_OK;
                     break;
                  end
               end
            end
         end
      end else if (w.address < model_base) begin
         r.status = STATUS_RANGE;
      end else begin
         // offset bits below the page size are dropped
         idx = 64'((w.address - model_base) >> model_shift);
         if (idx + 64'(w.run_pages) > 64'(lim)) begin
            r.status = STATUS_RANGE;
         end else begin
            for (int k = 0; k < w.run_pages; k++) page_map[int'(idx) + k] = 1'b0;
            r.status = STATUS_OK;
         end
      end
   endtask

   // sampled at the rising edge: register writes, result words, accepted request words
   always @(posedge clock) begin : monitor
      rsp_word_type model_rsp;
      rsp_word_type want;
      int           first_page;
      if (reset) begin
         model_base  = BASE_ADDRESS_RESET;
         model_shift = PAGE_SHIFT_RESET;
         model_pages = PAGES_IN_USE_RESET;
         foreach (page_map[i]) page_map[i] = 1'b0;
         expected_rsp_q.delete();
         live_runs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_ADDRESS: model_base = csr_wdata;
               CSR_PAGE_SHIFT:   model_shift = csr_wdata[SHIFT_BITS-1:0];
               CSR_PAGES_IN_USE: model_pages = csr_wdata[CNT_BITS-1:0];
               default: ;
            endcase
         end
         // the result word of the previous request comes before a new one is taken
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("result word with nothing pending", rsp_word.result_address,
                               32'h0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_word.result_address !== want.result_address)
                  report_mismatch("result_address", rsp_word.result_address,
                                  want.result_address);
               if (rsp_word.status !== want.status)
                  report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
            end
         end
         if (start && !busy) begin
            allocator_model(req_word, model_rsp, first_page);
            if (req_word.op == OP_ALLOC && model_rsp.status == STATUS_OK)
               live_runs.push_back('{first_page, int'(req_word.run_pages)});
            expected_rsp_q.push_back(golden_known ? golden_rsp : model_rsp);
         end
      end
   end

   // hold start low for the gap, while busy, and optionally until all results are back;
   // the word is then taken at the next rising edge since busy only moves there
   task automatic send_word(input req_word_type w, input int gap, input bit hold,
                            input bit known, input rsp_word_type known_rsp);
      @(negedge clock);
      while (gap > 0 || busy || (hold && expected_rsp_q.size() != 0)) begin
         start <= 1'b0;
         if (gap > 0) gap--;
         @(negedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      golden_known <= known;
      golden_rsp <= known_rsp;
   endtask

   // stop sending and wait for every pending result word
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [ADDR_BITS-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      req_word_type         w;
      rsp_word_type         r;
      page_run_type         pr;
      logic [ADDR_BITS-1:0] base;
      logic [SHIFT_BITS-1:0] shift;
      int                   gap;
      int                   lim;
      int                   k;
      bit                   burst;
      bit                   hold;
      start = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_index = CSR_BASE_ADDRESS;
      csr_wdata = '0;
      golden_known = 1'b0;
      golden_rsp = '0;
      burst = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; register rows only once the block has gone quiet
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_results();
            csr_write(dir_rows[i].csr_idx, dir_rows[i].data);
         end else begin
            w.op = dir_rows[i].op;
            w.run_pages = dir_rows[i].count;
            w.address = dir_rows[i].data;
            r.result_address = dir_rows[i].exp_address;
            r.status = dir_rows[i].exp_status;
            send_word(w, $urandom_range(0, 16), 1'b0, dir_rows[i].known, r);
         end
      end

      foreach (phases[p]) begin
         drain_results();
         base = phases[p].mixed ? 32'($urandom) : phases[p].base;
         shift = phases[p].mixed ? 5'($urandom_range(0, 20)) : phases[p].shift;
         csr_write(CSR_BASE_ADDRESS, base);
         csr_write(CSR_PAGE_SHIFT, 32'(shift));
         csr_write(CSR_PAGES_IN_USE, 32'(phases[p].pages));
         for (int n = 0; n < phases[p].items; n++) begin
            lim = (model_pages > NUM_PAGES) ? NUM_PAGES : int'(model_pages);
            w.op = OP_ALLOC;
            w.address = $urandom;
            w.run_pages = 11'd1;
            k = $urandom_range(0, 99);
            if (k < 50) begin
               // mostly small runs, sometimes up to the whole map, rarely anything
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5, 6: w.run_pages = 11'($urandom_range(1, 8));
                  7, 8: w.run_pages = 11'($urandom_range(1, (lim > 0) ? lim : 1));
                  default: w.run_pages = 11'($urandom_range(0, CNT_MAX));
               endcase
            end else if (k < 85 && live_runs.size() != 0) begin
               // give back a run handed out earlier, with random offset bits
               k = $urandom_range(0, live_runs.size() - 1);
               pr = live_runs[k];
               live_runs.delete(k);
               w.op = OP_FREE;
               w.address = model_base + (32'(pr.first) << model_shift)
                           + (32'($urandom) & ((32'd1 << model_shift) - 32'd1));
               w.run_pages = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, pr.len))
                                                        : 11'(pr.len);
            end else begin
               // noise: any op, any count, near-base or wild address
               w.op = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
               w.run_pages = 11'($urandom_range(0, CNT_MAX));
               w.address = $urandom_range(0, 1) ? 32'($urandom)
                           : model_base + (32'($urandom_range(0, 1100)) << model_shift);
            end
            if ($urandom_range(0, 19) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 16);
            hold = ($urandom_range(0, 39) == 0);
            send_word(w, gap, hold, 1'b0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch("result words never came", 32'(expected_rsp_q.size()), 32'h0);
      if (mismatch_count == 0) begin
         $display("[bitmap_page_allocator] OK");
      end else begin
         $display("[bitmap_page_allocator] ERROR");
      end
      $finish;
   end

endmodule
